@@ hdl/swfnfp_pkg.sv @@
// Shared types and constants for the network flag patcher.
// Used by swfnfp_emit and swf_network_flag_patcher_core; no dependencies.
package swfnfp_pkg;

  localparam int HOLD_DEPTH = 64;
  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int KW = $clog2(HOLD_DEPTH + 7);
  localparam int HW = 6;

  localparam logic [9:0] TAG_FILE_ATTRS = 10'd69;
  localparam logic [7:0] NET_FLAG_MASK = 8'h01;
  localparam logic [15:0] INS_WORD = {TAG_FILE_ATTRS, 6'd4};

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } hold_wr_t;

  typedef struct packed {
    logic          go;
    logic          ins;
    logic [1:0]    op;
    logic [CW-1:0] count;
    logic [HW-1:0] hend;
    logic [HW-1:0] fidx;
    logic [31:0]   newlen;
    logic          last;
    logic [2:0]    status;
  } flush_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } pass_req_t;

  function automatic logic [7:0] ins_byte(input logic [2:0] sel);
    logic [7:0] r;
    unique case (sel)
      3'd0:    r = INS_WORD[7:0];
      3'd1:    r = INS_WORD[15:8];
      3'd2:    r = NET_FLAG_MASK;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/swfnfp_emit.sv @@
// Hold store memory, burst flush sequencer and output register.
// Depends on swfnfp_pkg.
module swfnfp_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swfnfp_pkg::hold_wr_t   wr_i,
  input  swfnfp_pkg::flush_req_t req_i,
  input  swfnfp_pkg::pass_req_t  pass_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output swfnfp_pkg::out_item_t  out_item_o
);

  logic [7:0] mem [swfnfp_pkg::HOLD_DEPTH];

  logic                          busy_q;
  logic [swfnfp_pkg::KW-1:0]     k_q;
  logic                          ins_q;
  logic [1:0]                    op_q;
  logic [swfnfp_pkg::KW-1:0]     tot_q;
  logic [swfnfp_pkg::HW-1:0]     hend_q;
  logic [swfnfp_pkg::HW-1:0]     fidx_q;
  logic [31:0]                   newlen_q;
  logic                          last_q;
  logic [2:0]                    status_q;

  logic                          b_vld_q;
  logic                          b_ins_q;
  logic [7:0]                    b_insb_q;
  logic [swfnfp_pkg::KW-1:0]     b_idx_q;
  logic                          b_last_q;
  logic [7:0]                    rdata_q;

  logic                          out_vld_q;
  swfnfp_pkg::out_item_t         out_q;

  logic                          adv;
  logic                          a_ins;
  logic [2:0]                    a_sel;
  logic [swfnfp_pkg::KW-1:0]     a_idx;
  logic                          a_final;
  logic [swfnfp_pkg::KW-1:0]     hend_k;
  logic [7:0]                    fbyte;
  swfnfp_pkg::out_item_t         flush_item;

  assign adv = !out_vld_q || !out_stall_i;
  assign ready_o = !busy_q && !b_vld_q && adv;
  assign out_valid_o = out_vld_q;
  assign out_item_o = out_q;

  always_comb begin
    hend_k = swfnfp_pkg::KW'(hend_q);
    a_ins = 1'b0;
    a_sel = 3'd0;
    a_idx = k_q;
    if (ins_q && k_q >= hend_k) begin
      if (k_q < hend_k + swfnfp_pkg::KW'(6)) begin
        a_ins = 1'b1;
        a_sel = 3'(k_q - hend_k);
      end else begin
        a_idx = k_q - swfnfp_pkg::KW'(6);
      end
    end
    a_final = (k_q == tot_q - swfnfp_pkg::KW'(1));
  end

  always_comb begin
    fbyte = rdata_q;
    if (ins_q && b_idx_q >= swfnfp_pkg::KW'(4) && b_idx_q <= swfnfp_pkg::KW'(7)) begin
      fbyte = newlen_q[{b_idx_q[1:0], 3'b000} +: 8];
    end
    if (b_idx_q == swfnfp_pkg::KW'(fidx_q)) begin
      unique case (op_q)
        swfnfp_pkg::OP_SET:   fbyte = fbyte | swfnfp_pkg::NET_FLAG_MASK;
        swfnfp_pkg::OP_CLEAR: fbyte = fbyte & ~swfnfp_pkg::NET_FLAG_MASK;
        default:              fbyte = fbyte;
      endcase
    end
    if (b_ins_q) begin
      fbyte = b_insb_q;
    end
    flush_item.out_byte = fbyte;
    flush_item.out_last = b_last_q;
    flush_item.status = b_last_q ? status_q : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q <= '0;
      b_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        b_vld_q <= busy_q;
        out_vld_q <= b_vld_q || pass_i.valid;
        if (busy_q) begin
          k_q <= k_q + swfnfp_pkg::KW'(1);
          if (a_final) begin
            busy_q <= 1'b0;
          end
        end
      end
      if (req_i.go) begin
        busy_q <= 1'b1;
        k_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      ins_q <= req_i.ins;
      op_q <= req_i.op;
      tot_q <= swfnfp_pkg::KW'(req_i.count) + (req_i.ins ? swfnfp_pkg::KW'(6) : '0);
      hend_q <= req_i.hend;
      fidx_q <= req_i.fidx;
      newlen_q <= req_i.newlen;
      last_q <= req_i.last;
      status_q <= req_i.status;
    end
    if (adv && busy_q) begin
      b_ins_q <= a_ins;
      b_insb_q <= swfnfp_pkg::ins_byte(a_sel);
      b_idx_q <= a_idx;
      b_last_q <= last_q && a_final;
    end
    if (adv) begin
      out_q <= b_vld_q ? flush_item : pass_i.item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (adv && busy_q) begin
      rdata_q <= mem[a_idx[swfnfp_pkg::AW-1:0]];
    end
  end

endmodule

@@ hdl/swf_network_flag_patcher_core.sv @@
// Top level of the network flag patcher: header parser, decision logic and mode register.
// Depends on swfnfp_pkg and swfnfp_emit.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------------
//   in       | input     | in_valid_i / in_stall_o    | in_item_i  (in_byte, in_last)
//   out      | output    | out_valid_o / out_stall_i  | out_item_o (out_byte, out_last, status)
//   cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_data_i (mode)
//
// Header bytes produce no item until a decision is reached. Reset needs no clearing pass.
// The deciding byte starts a burst of count (+6 with an insert) items, one per cycle
// after a fill through the read and output registers, paced by the single read port
// of the hold store; input is stalled for the burst. Later bytes pass through at one
// item per cycle while the output is not stalled; a stall also freezes the burst in place.
module swf_network_flag_patcher_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  swfnfp_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output swfnfp_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_data_i
);

  localparam logic [2:0] PH_SIG = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_TAGHDR = 3'd2;
  localparam logic [2:0] PH_FLAGS = 3'd3;
  localparam logic [2:0] PH_PASS = 3'd4;
  localparam logic [2:0] PH_ERR = 3'd5;

  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [2:0] ST_CHANGED = 3'd0;
  localparam logic [2:0] ST_SET = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_BAD_SIG = 3'd3;
  localparam logic [2:0] ST_TOO_SHORT = 3'd4;
  localparam logic [2:0] ST_UNEXP_END = 3'd5;
  localparam logic [2:0] ST_TAG_SHORT = 3'd6;
  localparam logic [2:0] ST_COMPRESSED = 3'd7;

  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [5:0] SHORT_LEN_MASK = 6'h3F;
  localparam logic [4:0] RECT_COUNT_MASK = 5'h1F;

  logic [1:0]  mode_q;
  logic [31:0] pos_q, pos_d;
  logic [31:0] declen_q, declen_d;
  logic [5:0]  hend_q, hend_d;
  logic [9:0]  code_q, code_d;
  logic [31:0] tlen_q, tlen_d;
  logic        long_q, long_d;
  logic        flag_q, flag_d;
  logic [2:0]  phase_q, phase_d;
  logic [2:0]  outcome_q, outcome_d;

  logic        acc;
  logic        ready;
  logic        holding;
  logic [7:0]  b_in;
  logic        last_in;
  logic [5:0]  pos6;
  logic [5:0]  off;
  logic [5:0]  fdiff;
  logic [5:0]  bstart_q;
  logic [5:0]  bstart_d;
  logic [4:0]  rect;
  logic [5:0]  c3;
  logic        hdr_dec;
  logic [2:0]  fin_status;
  logic [32:0] len;
  logic [32:0] tag_end;

  swfnfp_pkg::hold_wr_t   wr;
  swfnfp_pkg::flush_req_t req;
  swfnfp_pkg::pass_req_t  pass;

  assign b_in = in_item_i.in_byte;
  assign last_in = in_item_i.in_last;
  assign acc = in_valid_i && ready;
  assign in_stall_o = !ready;
  assign cfg_ready_o = 1'b1;
  assign pos6 = pos_q[5:0];
  assign holding = (phase_q == PH_SIG) || (phase_q == PH_HEAD) ||
                   (phase_q == PH_TAGHDR) || (phase_q == PH_FLAGS);
  assign bstart_q = hend_q + (long_q ? 6'd6 : 6'd2);
  assign off = pos6 - hend_q;
  assign fdiff = pos6 - bstart_q;
  assign rect = b_in[7:3] & RECT_COUNT_MASK;
  assign c3 = {1'b0, rect} + 6'd3;

  assign wr.en = acc && holding && (pos_q < 32'(swfnfp_pkg::HOLD_DEPTH));
  assign wr.addr = pos_q[swfnfp_pkg::AW-1:0];
  assign wr.data = b_in;

  always_comb begin
    pos_d = pos_q;
    declen_d = declen_q;
    hend_d = hend_q;
    code_d = code_q;
    tlen_d = tlen_q;
    long_d = long_q;
    flag_d = flag_q;
    phase_d = phase_q;
    outcome_d = outcome_q;
    hdr_dec = 1'b0;
    req = '0;
    pass = '0;
    bstart_d = bstart_q;
    fin_status = ST_CHANGED;
    len = {1'b0, pos_q} + 33'd1;
    tag_end = '0;

    if (acc) begin
      unique case (phase_q)
        PH_SIG: begin
          if (pos6 == 6'd0) begin
            if (b_in != CH_F && b_in != CH_C) begin
              outcome_d = ST_BAD_SIG;
              phase_d = PH_ERR;
              req.go = 1'b1;
            end else begin
              outcome_d = (b_in == CH_C) ? ST_COMPRESSED : ST_CHANGED;
            end
          end else if (pos6 == 6'd1) begin
            if (b_in != CH_W) begin
              outcome_d = ST_BAD_SIG;
              phase_d = PH_ERR;
              req.go = 1'b1;
            end
          end else begin
            if (b_in != CH_S) begin
              outcome_d = ST_BAD_SIG;
              phase_d = PH_ERR;
              req.go = 1'b1;
            end else if (outcome_q == ST_COMPRESSED) begin
              outcome_d = ST_COMPRESSED;
              phase_d = PH_ERR;
              req.go = 1'b1;
            end else begin
              phase_d = PH_HEAD;
            end
          end
        end
        PH_HEAD: begin
          if (pos6 >= 6'd4 && pos6 <= 6'd7) begin
            declen_d = declen_q | (32'(b_in) << {pos6[1:0], 3'b000});
          end
          if (pos6 == 6'd8) begin
            hend_d = 6'd12 + {1'b0, c3[5:1]};
          end
          if (pos6 >= 6'd8 && (pos6 + 6'd1) == hend_d) begin
            phase_d = PH_TAGHDR;
          end
        end
        PH_TAGHDR: begin
          if (off == 6'd0) begin
            tlen_d = {26'd0, b_in[5:0] & SHORT_LEN_MASK};
            code_d = {8'd0, b_in[7:6]};
          end else if (off == 6'd1) begin
            code_d = {b_in, code_q[1:0]};
            if (tlen_q == {26'd0, SHORT_LEN_MASK}) begin
              long_d = 1'b1;
              tlen_d = '0;
            end else begin
              hdr_dec = 1'b1;
            end
          end else begin
            tlen_d = tlen_q | (32'(b_in) << {off[1:0] - 2'd2, 3'b000});
            hdr_dec = (off >= 6'd5);
          end
          if (hdr_dec) begin
            if (code_d == swfnfp_pkg::TAG_FILE_ATTRS) begin
              if (tlen_d < 32'd4) begin
                outcome_d = ST_TAG_SHORT;
                phase_d = PH_PASS;
                req.go = 1'b1;
              end else begin
                phase_d = PH_FLAGS;
              end
            end else begin
              phase_d = PH_PASS;
              req.go = 1'b1;
              if (mode_q == MODE_ADD) begin
                outcome_d = ST_CHANGED;
                req.ins = 1'b1;
              end else begin
                outcome_d = ST_CLEAR;
              end
            end
          end
        end
        PH_FLAGS: begin
          if (pos6 == bstart_q) begin
            flag_d = b_in[0];
          end
          if (fdiff >= 6'd3) begin
            phase_d = PH_PASS;
            req.go = 1'b1;
            if (mode_q == MODE_ADD) begin
              outcome_d = flag_q ? ST_SET : ST_CHANGED;
              req.op = flag_q ? swfnfp_pkg::OP_NONE : swfnfp_pkg::OP_SET;
            end else if (mode_q == MODE_REMOVE) begin
              outcome_d = flag_q ? ST_CHANGED : ST_CLEAR;
              req.op = flag_q ? swfnfp_pkg::OP_CLEAR : swfnfp_pkg::OP_NONE;
            end else begin
              outcome_d = flag_q ? ST_SET : ST_CLEAR;
            end
          end
        end
        default: begin
          pass.valid = 1'b1;
        end
      endcase

      bstart_d = hend_d + (long_d ? 6'd6 : 6'd2);
      tag_end = 33'(bstart_d) + {1'b0, tlen_d};
      unique case (phase_d)
        PH_SIG, PH_HEAD: fin_status = ST_TOO_SHORT;
        PH_TAGHDR:       fin_status = ST_UNEXP_END;
        PH_ERR:          fin_status = (len < 33'd8) ? ST_TOO_SHORT : outcome_d;
        default:         fin_status = (len < tag_end) ? ST_UNEXP_END : outcome_d;
      endcase

      if (last_in && holding) begin
        req.go = 1'b1;
      end
      req.count = swfnfp_pkg::CW'(pos6) + swfnfp_pkg::CW'(1);
      req.hend = hend_d;
      req.fidx = bstart_d;
      req.newlen = declen_d + 32'd6;
      req.last = last_in;
      req.status = fin_status;
      pass.item.out_byte = b_in;
      pass.item.out_last = last_in;
      pass.item.status = last_in ? fin_status : 3'd0;

      if (last_in) begin
        pos_d = '0;
        declen_d = '0;
        hend_d = '0;
        code_d = '0;
        tlen_d = '0;
        long_d = 1'b0;
        flag_d = 1'b0;
        phase_d = PH_SIG;
        outcome_d = ST_CHANGED;
      end else if (pos_q != '1) begin
        pos_d = pos_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
      pos_q <= '0;
      declen_q <= '0;
      hend_q <= '0;
      code_q <= '0;
      tlen_q <= '0;
      long_q <= 1'b0;
      flag_q <= 1'b0;
      phase_q <= PH_SIG;
      outcome_q <= ST_CHANGED;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      pos_q <= pos_d;
      declen_q <= declen_d;
      hend_q <= hend_d;
      code_q <= code_d;
      tlen_q <= tlen_d;
      long_q <= long_d;
      flag_q <= flag_d;
      phase_q <= phase_d;
      outcome_q <= outcome_d;
    end
  end

  swfnfp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .req_i       (req),
    .pass_i      (pass),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.out_last |-> out_item_o.status == 3'd0)
    else $error("Status is nonzero on an item that is not the last.");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_in |=> pos_q == '0 && phase_q == PH_SIG)
    else $error("Parser did not restart after the last item of a file.");

  a_hold_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && holding |-> pos_q < 32'(swfnfp_pkg::HOLD_DEPTH))
    else $error("Held header grew beyond the hold store.");

  a_burst_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req.go |=> in_stall_o)
    else $error("Input was not stalled at the start of a burst.");
`endif

endmodule
